/* design/matrix_multiply_engine_macros.svh */
// Assertion macros of the matrix multiply engine top level.
`ifndef MATRIX_MULTIPLY_ENGINE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define MME_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MME_ASSERT_SAME(lbl, ante, cons, msg)
`define MME_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/mme_pkg.sv */
// Shared types, codes and sizes of the matrix multiply engine.
package mme_pkg;

  localparam int MAX_DIM   = 16;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int DIM_W     = IDX_W + 1;
  localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int VAL_W     = 32;
  localparam int ACC_W     = 64;
  localparam int FRAC_W    = 16;

  localparam logic [1:0] OP_WR_A    = 2'd0;
  localparam logic [1:0] OP_WR_B    = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic [1:0] CFG_ROWS_A = 2'd0;
  localparam logic [1:0] CFG_INNER  = 2'd1;
  localparam logic [1:0] CFG_COLS_B = 2'd2;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] product_value;
    logic [1:0]              status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             wr_a;
    logic             wr_b;
    logic             rd_en;
    logic [IDX_W-1:0] rd_k;
    logic             resp_ok;
    logic             resp_err;
    logic             resp_cmp;
  } mme_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             wr_a_ok;
    logic             wr_b_ok;
    logic             cmp_ok;
    logic [DIM_W-1:0] inner_len;
    logic             pipe_empty;
  } mme_stat_t;

  function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v);
    eff_size = (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
  endfunction

endpackage

/* design/mme_datapath.sv */
// Datapath: size registers, element stores, multiply-accumulate and result register.
module mme_datapath import mme_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  logic       cfg_wr,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data,
  input  mme_cmd_t   cmd,
  output mme_stat_t  stat,
  output logic       out_valid,
  output out_item_t  out_data
);

  logic [DIM_W-1:0] rows_a_r, inner_r, cols_b_r;
  logic [DIM_W-1:0] m_eff, r_eff, n_eff;
  logic [IDX_W-1:0] row_r, col_r;

  logic [VAL_W-1:0] a_mem [MEM_DEPTH];
  logic [VAL_W-1:0] b_mem [MEM_DEPTH];
  logic signed [VAL_W-1:0] a_q_r, b_q_r;
  logic signed [ACC_W-1:0] prod_r, acc_r;
  logic             rd_vld_r, mul_vld_r;
  logic [ACC_W:0]   sum;
  logic signed [ACC_W-FRAC_W-1:0] q;
  logic             q_hi, q_lo;
  logic             out_valid_r;
  out_item_t        out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= DIM_W'(MAX_DIM);
      inner_r  <= DIM_W'(MAX_DIM);
      cols_b_r <= DIM_W'(MAX_DIM);
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_ROWS_A: rows_a_r <= DIM_W'(cfg_data);
        CFG_INNER:  inner_r  <= DIM_W'(cfg_data);
        CFG_COLS_B: cols_b_r <= DIM_W'(cfg_data);
        default: ;
      endcase
    end
  end

  assign m_eff = eff_size(rows_a_r);
  assign r_eff = eff_size(inner_r);
  assign n_eff = eff_size(cols_b_r);

  always_comb begin
    stat.wr_a_ok = (in_data.opcode == OP_WR_A) &&
                   ({1'b0, in_data.row_index} < m_eff) &&
                   ({1'b0, in_data.col_index} < r_eff);
    stat.wr_b_ok = (in_data.opcode == OP_WR_B) &&
                   ({1'b0, in_data.row_index} < r_eff) &&
                   ({1'b0, in_data.col_index} < n_eff);
    stat.cmp_ok  = (in_data.opcode == OP_COMPUTE) &&
                   ({1'b0, in_data.row_index} < m_eff) &&
                   ({1'b0, in_data.col_index} < n_eff);
    stat.inner_len  = r_eff;
    stat.pipe_empty = !rd_vld_r && !mul_vld_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_r <= in_data.row_index;
      col_r <= in_data.col_index;
    end
  end

  // A is addressed row-major by (row, k); B by (k, col).
  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      a_mem[{in_data.row_index, in_data.col_index}] <= in_data.element_value;
    end
    if (cmd.rd_en) begin
      a_q_r <= a_mem[{row_r, cmd.rd_k}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b) begin
      b_mem[{in_data.row_index, in_data.col_index}] <= in_data.element_value;
    end
    if (cmd.rd_en) begin
      b_q_r <= b_mem[{cmd.rd_k, col_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
    end else begin
      rd_vld_r  <= cmd.rd_en;
      mul_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      prod_r <= a_q_r * b_q_r;
    end
  end

  // Signed add with one guard bit; a guard bit that disagrees with the sign means overflow.
  assign sum = {acc_r[ACC_W-1], acc_r} + {prod_r[ACC_W-1], prod_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r <= '0;
    end else if (mul_vld_r) begin
      if (sum[ACC_W] != sum[ACC_W-1]) begin
        acc_r <= sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        acc_r <= sum[ACC_W-1:0];
      end
    end
  end

  // Arithmetic shift floors toward minus infinity, then clamp to 32 bits.
  assign q    = acc_r[ACC_W-1:FRAC_W];
  assign q_hi = !q[ACC_W-FRAC_W-1] && (|q[ACC_W-FRAC_W-2:VAL_W-1]);
  assign q_lo = q[ACC_W-FRAC_W-1] && !(&q[ACC_W-FRAC_W-2:VAL_W-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.resp_ok || cmd.resp_err || cmd.resp_cmp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_cmp) begin
      if (q_hi) begin
        out_data_r.product_value <= {1'b0, {(VAL_W-1){1'b1}}};
        out_data_r.status        <= ST_SAT;
      end else if (q_lo) begin
        out_data_r.product_value <= {1'b1, {(VAL_W-1){1'b0}}};
        out_data_r.status        <= ST_SAT;
      end else begin
        out_data_r.product_value <= q[VAL_W-1:0];
        out_data_r.status        <= ST_OK;
      end
    end else if (cmd.resp_ok) begin
      out_data_r.product_value <= '0;
      out_data_r.status        <= ST_OK;
    end else if (cmd.resp_err) begin
      out_data_r.product_value <= '0;
      out_data_r.status        <= ST_RANGE;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/mme_ctrl.sv */
// Controller: decodes accepted items and sequences the inner-product terms.
module mme_ctrl import mme_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  mme_stat_t stat,
  output logic      busy,
  output mme_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             last_k;

  assign last_k = ({1'b0, k_r} + DIM_W'(1)) == stat.inner_len;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cmd       = '0;
    cmd.rd_k  = k_r;
    case (state_r)
      S_IDLE: begin
        if (start && rst_n) begin
          if (stat.wr_a_ok) begin
            cmd.wr_a    = 1'b1;
            cmd.resp_ok = 1'b1;
          end else if (stat.wr_b_ok) begin
            cmd.wr_b    = 1'b1;
            cmd.resp_ok = 1'b1;
          end else if (stat.cmp_ok) begin
            cmd.load  = 1'b1;
            k_nxt     = '0;
            state_nxt = (stat.inner_len == '0) ? S_DRAIN : S_ISSUE;
          end else begin
            cmd.resp_err = 1'b1;
          end
        end
      end
      S_ISSUE: begin
        cmd.rd_en = 1'b1;
        k_nxt     = k_r + IDX_W'(1);
        if (last_k) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last term has left the multiplier and sits in the accumulator.
        if (stat.pipe_empty) begin
          cmd.resp_cmp = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  assign busy = !rst_n || (state_r != S_IDLE);

endmodule

/* design/matrix_multiply_engine.sv */
// Top level of the matrix multiply engine: controller plus datapath.
//
//   Channel | Ports                                  | Transfer
//   --------+----------------------------------------+-------------------------------
//   input   | start, busy, in_data                   | start && !busy
//   result  | out_valid, out_data                    | every cycle out_valid is high
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// A write or a rejected item is answered from the idle state; its result appears the next cycle
// and busy stays low. A compute item holds busy while its terms pass, one term per cycle,
// through the single multiply-accumulate unit: memory read, multiply and accumulate
// registers. Its result appears in the first cycle with busy low again. Reset is
// synchronous and active low; it restores all sizes to 16 and leaves the stores as they
// are. The receiver cannot stall, so each result is shown for exactly one cycle.
`include "matrix_multiply_engine_macros.svh"
module matrix_multiply_engine import mme_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_data,
  output logic       out_valid,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data
);

  mme_cmd_t  cmd;
  mme_stat_t stat;
  logic      item_xfer;

  assign cfg_ready = rst_n;
  assign item_xfer = start && !busy;

  mme_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  mme_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `MME_ASSERT_NEXT(a_short_answers, item_xfer && !stat.cmp_ok, out_valid && !busy, "no result")
  `MME_ASSERT_NEXT(a_compute_busy, item_xfer && stat.cmp_ok, busy && !out_valid, "not busy")
  `MME_ASSERT_SAME(a_no_result_while_busy, out_valid, !busy, "result strobe while busy")

endmodule

/* test/matrix_multiply_engine_tb.sv */
// Self-checking testbench of the matrix multiply engine: loads, products, range errors.
module matrix_multiply_engine_tb;
  import mme_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 500;
  localparam int SETTLE_CYCLES = 30;

  localparam logic [VAL_W-1:0] Q_MAX     = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0] Q_MIN     = 32'h8000_0000;
  localparam logic [VAL_W-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [VAL_W-1:0] Q_NEG_ONE = 32'hffff_0000;
  localparam logic [VAL_W-1:0] Q_LSB     = 32'h0000_0001;
  localparam logic [VAL_W-1:0] Q_NEG_LSB = 32'hffff_ffff;

  // Mirror of both element stores and the size registers; predicts each result.
  class mme_scoreboard;
    logic [VAL_W-1:0] a_mem [MEM_DEPTH];
    logic [VAL_W-1:0] b_mem [MEM_DEPTH];
    bit               a_seen [MEM_DEPTH];
    bit               b_seen [MEM_DEPTH];
    logic [4:0]       rows_cfg;
    logic [4:0]       inner_cfg;
    logic [4:0]       cols_cfg;
    out_item_t        pending_outputs [$];
    int unsigned      errors;

    function new();
      rows_cfg  = 5'd16;
      inner_cfg = 5'd16;
      cols_cfg  = 5'd16;
      errors    = 0;
      foreach (a_seen[i]) begin
        a_seen[i] = 1'b0;
        b_seen[i] = 1'b0;
        a_mem[i]  = '0;
        b_mem[i]  = '0;
      end
    endfunction

    function int dim(input logic [4:0] v);
      return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    function void set_size(input logic [1:0] idx, input logic [4:0] val);
      case (idx)
        CFG_ROWS_A: rows_cfg = val;
        CFG_INNER:  inner_cfg = val;
        CFG_COLS_B: cols_cfg = val;
        default: ;
      endcase
    endfunction

    function out_item_t dot_product(input int row, input int col);
      out_item_t res;
      longint    acc;
      longint    x;
      longint    y;
      longint    term;
      longint    sum;
      longint    q;
      acc = 0;
      for (int k = 0; k < dim(inner_cfg); k++) begin
        x = $signed(a_mem[row * MAX_DIM + k]);
        y = $signed(b_mem[k * MAX_DIM + col]);
        term = x * y;
        sum = acc + term;
        // Each addition clamps at the 64-bit limits instead of wrapping.
        if (acc > 0 && term > 0 && sum < 0) begin
          sum = 64'sh7fff_ffff_ffff_ffff;
        end else if (acc < 0 && term < 0 && sum >= 0) begin
          sum = 64'sh8000_0000_0000_0000;
        end
        acc = sum;
      end
      q = acc >>> FRAC_W;
      if (q > 64'sd2147483647) begin
        res.product_value = Q_MAX;
        res.status = ST_SAT;
      end else if (q < -64'sd2147483648) begin
        res.product_value = Q_MIN;
        res.status = ST_SAT;
      end else begin
        res.product_value = q[VAL_W-1:0];
        res.status = ST_OK;
      end
      return res;
    endfunction

    function void predict_command(input in_item_t it);
      out_item_t res;
      int        row;
      int        col;
      int        m;
      int        r;
      int        n;
      row = it.row_index;
      col = it.col_index;
      m = dim(rows_cfg);
      r = dim(inner_cfg);
      n = dim(cols_cfg);
      res.product_value = '0;
      res.status = ST_RANGE;
      case (it.opcode)
        OP_WR_A: if (row < m && col < r) begin
          a_mem[row * MAX_DIM + col] = it.element_value;
          a_seen[row * MAX_DIM + col] = 1'b1;
          res.status = ST_OK;
        end
        OP_WR_B: if (row < r && col < n) begin
          b_mem[row * MAX_DIM + col] = it.element_value;
          b_seen[row * MAX_DIM + col] = 1'b1;
          res.status = ST_OK;
        end
        OP_COMPUTE: if (row < m && col < n) begin
          res = dot_product(row, col);
        end
        default: ;
      endcase
      pending_outputs.push_back(res);
    endfunction

    function void compare_output(input out_item_t got);
      out_item_t want;
      if (pending_outputs.size() == 0) begin
        $error("unexpected result: product_value %h status %0d", got.product_value, got.status);
        errors++;
        return;
      end
      want = pending_outputs.pop_front();
      if (got.product_value !== want.product_value) begin
        $error("product_value: expected %h, actual %h", want.product_value, got.product_value);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction

    function int pending();
      return pending_outputs.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;

  mme_scoreboard board;
  bit            steady;
  int unsigned   cycle_count;

  matrix_multiply_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      board.compare_output(out_data);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("matrix_multiply_engine: mismatch");
    $finish;
  end

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 25) return $urandom();
    if (p < 32) return Q_MIN;
    if (p < 40) return Q_MAX;
    if (p < 45) return '0;
    if (p < 50) return Q_NEG_LSB;
    // Modest magnitudes keep most sums inside the Q16.16 range.
    return VAL_W'(int'($urandom_range(32'h20_0000)) - 32'sh10_0000);
  endfunction

  function automatic logic [4:0] pick_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 8) return 5'd0;
    if (p < 20) return 5'd1;
    if (p < 30) return 5'd16;
    if (p < 38) return 5'($urandom_range(31, 17));
    if (p < 42) return 5'd31;
    return 5'($urandom_range(6, 2));
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(input int size);
    if (size == 0 || $urandom_range(99) < 10) return IDX_W'($urandom_range(MAX_DIM - 1));
    return IDX_W'($urandom_range(size - 1));
  endfunction

  function automatic in_item_t command(input logic [1:0] op, input int row, input int col,
                                       input logic [VAL_W-1:0] val);
    in_item_t it;
    it.opcode = op;
    it.row_index = IDX_W'(row);
    it.col_index = IDX_W'(col);
    it.element_value = val;
    return it;
  endfunction

  // A product may only read loaded elements; the first unloaded operand is written instead.
  function automatic in_item_t load_missing(input in_item_t it);
    in_item_t w;
    int       row;
    int       col;
    row = it.row_index;
    col = it.col_index;
    w = it;
    if (it.opcode == OP_COMPUTE && row < board.dim(board.rows_cfg)
        && col < board.dim(board.cols_cfg)) begin
      for (int k = board.dim(board.inner_cfg) - 1; k >= 0; k--) begin
        if (!board.b_seen[k * MAX_DIM + col]) w = command(OP_WR_B, k, col, pick_value());
        if (!board.a_seen[row * MAX_DIM + k]) w = command(OP_WR_A, row, k, pick_value());
      end
    end
    return w;
  endfunction

  function automatic in_item_t random_command();
    in_item_t    it;
    int unsigned p;
    int          m;
    int          r;
    int          n;
    m = board.dim(board.rows_cfg);
    r = board.dim(board.inner_cfg);
    n = board.dim(board.cols_cfg);
    p = $urandom_range(99);
    it.element_value = pick_value();
    if (p < 45) begin
      it.opcode = OP_COMPUTE;
      it.row_index = pick_index(m);
      it.col_index = pick_index(n);
    end else if (p < 65) begin
      it.opcode = OP_WR_A;
      it.row_index = pick_index(m);
      it.col_index = pick_index(r);
    end else if (p < 85) begin
      it.opcode = OP_WR_B;
      it.row_index = pick_index(r);
      it.col_index = pick_index(n);
    end else if (p < 92) begin
      it.opcode = OP_UNUSED;
      it.row_index = IDX_W'($urandom());
      it.col_index = IDX_W'($urandom());
    end else begin
      it.opcode = 2'($urandom());
      it.row_index = IDX_W'($urandom());
      it.col_index = IDX_W'($urandom());
    end
    return load_missing(it);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_command(input in_item_t it);
    while (!steady && $urandom_range(99) < 35) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.predict_command(it);
    @(negedge clk);
  endtask

  task automatic write_size(input logic [1:0] idx, input logic [4:0] val);
    while ($urandom_range(99) < 35) begin
      cfg_valid <= 1'b0;
      @(negedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_size(idx, val);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int sent;
    int burst;
    board = new();
    steady = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ROWS_A;
    cfg_data = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // One inner term, rows above the limit: each product is a single exact term.
    write_size(CFG_ROWS_A, 5'd31);
    write_size(CFG_INNER, 5'd1);
    cfg_valid <= 1'b0;
    send_command(command(OP_WR_A, 0, 0, Q_MAX));
    send_command(command(OP_WR_B, 0, 0, Q_MAX));
    send_command(command(OP_COMPUTE, 0, 0, $urandom()));
    send_command(command(OP_WR_A, 15, 0, Q_MIN));
    send_command(command(OP_WR_B, 0, 15, Q_MAX));
    send_command(command(OP_COMPUTE, 15, 15, $urandom()));
    send_command(command(OP_WR_A, 1, 0, Q_MIN));
    send_command(command(OP_WR_B, 0, 1, Q_MIN));
    send_command(command(OP_COMPUTE, 1, 1, $urandom()));
    send_command(command(OP_WR_A, 2, 0, Q_ONE));
    send_command(command(OP_WR_B, 0, 2, Q_NEG_ONE));
    send_command(command(OP_COMPUTE, 2, 2, $urandom()));
    // A tiny negative product must round toward minus infinity.
    send_command(command(OP_WR_A, 3, 0, Q_LSB));
    send_command(command(OP_WR_B, 0, 3, Q_NEG_LSB));
    send_command(command(OP_COMPUTE, 3, 3, $urandom()));
    send_command(command(OP_WR_A, 0, 1, Q_ONE));
    send_command(command(OP_WR_B, 1, 0, Q_ONE));
    send_command(command(OP_UNUSED, 15, 15, Q_NEG_LSB));

    // Zero columns: every product and every B load is out of range.
    wait_drained();
    write_size(CFG_COLS_B, 5'd0);
    cfg_valid <= 1'b0;
    send_command(command(OP_COMPUTE, 0, 0, $urandom()));
    send_command(command(OP_WR_B, 0, 0, Q_ONE));

    // Zero inner length gives an empty sum.
    wait_drained();
    write_size(CFG_COLS_B, 5'd16);
    write_size(CFG_INNER, 5'd0);
    cfg_valid <= 1'b0;
    send_command(command(OP_COMPUTE, 0, 0, $urandom()));
    send_command(command(OP_WR_A, 0, 0, Q_ONE));

    // Two largest positive terms overflow the 64-bit accumulator.
    wait_drained();
    write_size(CFG_INNER, 5'd2);
    cfg_valid <= 1'b0;
    send_command(command(OP_WR_A, 4, 0, Q_MIN));
    send_command(command(OP_WR_A, 4, 1, Q_MIN));
    send_command(command(OP_WR_B, 0, 4, Q_MIN));
    send_command(command(OP_WR_B, 1, 4, Q_MIN));
    send_command(command(OP_COMPUTE, 4, 4, $urandom()));

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      write_size(CFG_ROWS_A, pick_size());
      write_size(CFG_INNER, pick_size());
      write_size(CFG_COLS_B, pick_size());
      cfg_valid <= 1'b0;
      burst = $urandom_range(70, 30);
      repeat (burst) begin
        steady = (sent >= 150 && sent < 300);
        send_command(random_command());
        sent++;
      end
    end
    steady = 1'b0;

    wait_drained();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("matrix_multiply_engine: match");
    end else begin
      $display("matrix_multiply_engine: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/mme_pkg.sv
design/mme_datapath.sv
design/mme_ctrl.sv
design/matrix_multiply_engine.sv
test/matrix_multiply_engine_tb.sv
